@@ hw/rtl/fnmb_pkg.sv @@
// shared constants and types of the four-neighbour mean blur
package fnmb_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int MAX_HEIGHT     = 2048;
	localparam int CFG_W          = 12;
	localparam int CFG_IDX_W      = 1;
	localparam int PIX_PORT_W     = 16;
	localparam int ROW_W          = $clog2(MAX_HEIGHT + 1);
	localparam int QUEUE_DEPTH    = 4;
	localparam int NB_SHIFT       = 2;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1920);
	localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1080);

	localparam logic MODE_PIXEL = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	// one issued item on its way from the front to the back
	typedef struct packed {
		logic valid;
		logic produce;
		logic first;
		logic flush;
		logic eor;
		logic eof;
		logic fwd;
	} fnmb_issue_t;

endpackage

@@ hw/rtl/fnmb_ifs.sv @@
// handshake channels of the four-neighbour mean blur
interface fnmb_in_if;
	import fnmb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  mode;
	logic [PIX_PORT_W-1:0] pixel_in;
	modport source (output valid, mode, pixel_in, input ready);
	modport sink (input valid, mode, pixel_in, output ready);
endinterface

interface fnmb_out_if;
	import fnmb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIX_PORT_W-1:0] blurred;
	logic                  end_of_row;
	logic                  end_of_frame;
	modport source (output valid, blurred, end_of_row, end_of_frame, input ready);
	modport sink (input valid, blurred, end_of_row, end_of_frame, output ready);
endinterface

interface fnmb_cfg_if;
	import fnmb_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/four_neighbor_mean_blur.sv @@
// top level of the streaming four-neighbour mean blur
// Pixels enter on the pixels channel in raster order (mode pixel), one transfer per
// pixel; once the frame's rows are all in, flush transfers (mode flush) drain the
// last row, one result each. Results leave on the results channel: the result for
// row r goes out when the pixel below it is taken, the first row gives none.
// Pixels arriving while the frame drains, and flushes before it is complete, are
// dropped without a result. Width and height are written on the cfg channel
// (index 0 width, index 1 height); the user must write them only while the block
// is idle, which the block itself does not enforce; every write restarts the frame.
// A result passes the issue register, the queue and the output register; one item
// can be taken every clock while the queue has room: the front issues line store reads,
// the back sums the four neighbours from a four-entry queue into the output register.
// When the receiver stalls, the queue fills and pixels.ready falls; it rises again
// as soon as the receiver takes results.
// Reset sets a 1920 by 1080 frame and clears the counters; the line stores are
// not cleared, since the first row of each frame writes them before any read.
module four_neighbor_mean_blur #(
	parameter int MAX_WIDTH  = fnmb_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = fnmb_pkg::PIXEL_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fnmb_in_if.sink     pixels,
	fnmb_out_if.source  results,
	fnmb_cfg_if.sink    cfg
);
	import fnmb_pkg::*;

	localparam int PW = (PIXEL_BITS < PIX_PORT_W) ? PIXEL_BITS : PIX_PORT_W;
	localparam int AW = $clog2(MAX_WIDTH);

	fnmb_issue_t   issue_s1;
	logic [PW-1:0] pix_s1;
	logic          room;
	logic [AW-1:0] cur_a_addr;
	logic [AW-1:0] cur_b_addr;
	logic [AW-1:0] above_rd_addr;
	logic          cur_wr_en;
	logic [AW-1:0] cur_wr_addr;
	logic [PW-1:0] cur_wr_data;
	logic          above_wr_en;
	logic [AW-1:0] above_wr_addr;
	logic [PW-1:0] above_wr_data;
	logic [PW-1:0] cur_a_data;
	logic [PW-1:0] cur_b_data;
	logic [PW-1:0] above_data;

	fnmb_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.PW        (PW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.pixels        (pixels),
		.cfg           (cfg),
		.room          (room),
		.cur_a_data    (cur_a_data),
		.cur_a_addr    (cur_a_addr),
		.cur_b_addr    (cur_b_addr),
		.above_rd_addr (above_rd_addr),
		.cur_wr_en     (cur_wr_en),
		.cur_wr_addr   (cur_wr_addr),
		.cur_wr_data   (cur_wr_data),
		.above_wr_en   (above_wr_en),
		.above_wr_addr (above_wr_addr),
		.above_wr_data (above_wr_data),
		.issue_s1      (issue_s1),
		.pix_s1        (pix_s1)
	);

	// two copies of the current row give two reads a cycle
	fnmb_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_cur_a (
		.clk     (clk),
		.wr_en   (cur_wr_en),
		.wr_addr (cur_wr_addr),
		.wr_data (cur_wr_data),
		.rd_addr (cur_a_addr),
		.rd_data (cur_a_data)
	);

	fnmb_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_cur_b (
		.clk     (clk),
		.wr_en   (cur_wr_en),
		.wr_addr (cur_wr_addr),
		.wr_data (cur_wr_data),
		.rd_addr (cur_b_addr),
		.rd_data (cur_b_data)
	);

	fnmb_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_WIDTH)
	) u_above (
		.clk     (clk),
		.wr_en   (above_wr_en),
		.wr_addr (above_wr_addr),
		.wr_data (above_wr_data),
		.rd_addr (above_rd_addr),
		.rd_data (above_data)
	);

	fnmb_back #(
		.PW (PW),
		.QD (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue_s1   (issue_s1),
		.pix_s1     (pix_s1),
		.cur_a_data (cur_a_data),
		.cur_b_data (cur_b_data),
		.above_data (above_data),
		.room       (room),
		.results    (results)
	);

endmodule

@@ hw/rtl/fnmb_ram.sv @@
// generic single-write single-read ram with registered read data
module fnmb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	// read returns the old contents when the same entry is written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

@@ hw/rtl/fnmb_front.sv @@
// front end: configuration, frame counters, item classification and line store access
module fnmb_front #(
	parameter int MAX_WIDTH = fnmb_pkg::MAX_WIDTH_DEF,
	parameter int PW = fnmb_pkg::PIXEL_BITS_DEF,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fnmb_in_if.sink               pixels,
	fnmb_cfg_if.sink              cfg,
	input  logic                  room,
	input  logic [PW-1:0]         cur_a_data,
	output logic [AW-1:0]         cur_a_addr,
	output logic [AW-1:0]         cur_b_addr,
	output logic [AW-1:0]         above_rd_addr,
	output logic                  cur_wr_en,
	output logic [AW-1:0]         cur_wr_addr,
	output logic [PW-1:0]         cur_wr_data,
	output logic                  above_wr_en,
	output logic [AW-1:0]         above_wr_addr,
	output logic [PW-1:0]         above_wr_data,
	output fnmb_pkg::fnmb_issue_t issue_s1,
	output logic [PW-1:0]         pix_s1
);
	import fnmb_pkg::*;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [AW-1:0]    last_col;
	logic [ROW_W-1:0] h_use;
	logic [AW-1:0]    col_q;
	logic [AW-1:0]    drain_q;
	logic [ROW_W-1:0] row_q;
	logic [AW-1:0]    col_s1;

	logic          accept;
	logic          flush;
	logic          draining;
	logic          issue;
	logic          last;
	logic          row0;
	logic          wr_above_s2;
	logic [AW-1:0] col;
	logic [AW-1:0] right;
	logic [PW-1:0] pix;

	assign cfg.ready    = 1'b1;
	assign pixels.ready = room;

	always_comb begin
		if (width_q == '0) begin
			last_col = '0;
		end else if (int'(width_q) > MAX_WIDTH) begin
			last_col = AW'(MAX_WIDTH - 1);
		end else begin
			last_col = AW'(width_q - CFG_W'(1));
		end
		if (height_q == '0) begin
			h_use = ROW_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_use = ROW_W'(MAX_HEIGHT);
		end else begin
			h_use = ROW_W'(height_q);
		end
	end

	assign accept   = pixels.valid && pixels.ready;
	assign flush    = (pixels.mode == MODE_FLUSH);
	assign draining = (row_q >= h_use);
	assign issue    = accept && (flush ? draining : !draining);
	assign col      = flush ? drain_q : col_q;
	assign last     = (col == last_col);
	assign right    = last ? col : col + AW'(1);
	assign row0     = !flush && (row_q == '0);
	assign pix      = PW'(pixels.pixel_in);

	assign cur_a_addr    = col;
	assign cur_b_addr    = right;
	assign above_rd_addr = col;
	assign cur_wr_en     = issue && !flush;
	assign cur_wr_addr   = col;
	assign cur_wr_data   = pix;

	// the row above gets the old current pixel once it is back from the store
	assign wr_above_s2 = issue_s1.valid && issue_s1.produce && !issue_s1.flush;

	always_comb begin
		if (issue && row0) begin
			above_wr_en   = 1'b1;
			above_wr_addr = col;
			above_wr_data = pix;
		end else begin
			above_wr_en   = wr_above_s2;
			above_wr_addr = col_s1;
			above_wr_data = cur_a_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			drain_q  <= '0;
			row_q    <= '0;
			issue_s1 <= '0;
		end else begin
			issue_s1.valid   <= issue;
			issue_s1.produce <= issue && !row0;
			issue_s1.first   <= (col == '0);
			issue_s1.flush   <= flush;
			issue_s1.eor     <= last;
			issue_s1.eof     <= last && flush;
			// only a one-pixel row reads the entry that the item ahead writes in the same cycle
			issue_s1.fwd     <= wr_above_s2 && (col_s1 == col);
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_FRAME_WIDTH:  width_q <= cfg.data;
					REG_FRAME_HEIGHT: height_q <= cfg.data;
					default: ;
				endcase
				col_q   <= '0;
				drain_q <= '0;
				row_q   <= '0;
			end else if (issue) begin
				if (flush) begin
					if (last) begin
						col_q   <= '0;
						drain_q <= '0;
						row_q   <= '0;
					end else begin
						drain_q <= drain_q + AW'(1);
					end
				end else if (last) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col;
		pix_s1 <= pix;
	end

endmodule

@@ hw/rtl/fnmb_back.sv @@
// back end: neighbour gathering, work queue, four-way sum and output register
module fnmb_back #(
	parameter int PW = fnmb_pkg::PIXEL_BITS_DEF,
	parameter int QD = fnmb_pkg::QUEUE_DEPTH,
	localparam int QAW = $clog2(QD),
	localparam int QCW = $clog2(QD + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fnmb_pkg::fnmb_issue_t issue_s1,
	input  logic [PW-1:0]         pix_s1,
	input  logic [PW-1:0]         cur_a_data,
	input  logic [PW-1:0]         cur_b_data,
	input  logic [PW-1:0]         above_data,
	output logic                  room,
	fnmb_out_if.source            results
);
	import fnmb_pkg::*;

	typedef struct packed {
		logic [PW-1:0] left;
		logic [PW-1:0] right;
		logic [PW-1:0] up;
		logic [PW-1:0] down;
		logic          eor;
		logic          eof;
	} entry_t;

	entry_t           queue_q [QD];
	entry_t           push_entry;
	entry_t           head;
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic [PW-1:0]    held_q;
	logic             push;
	logic             pop;
	logic [PW+1:0]    sum;
	logic             out_valid_q;
	logic [PW-1:0]    blurred_q;
	logic             eor_q;
	logic             eof_q;

	assign push = issue_s1.valid && issue_s1.produce;

	// held_q is the old current pixel one column to the left
	always_comb begin
		push_entry.left  = issue_s1.first ? cur_a_data : held_q;
		push_entry.right = cur_b_data;
		push_entry.up    = issue_s1.fwd ? held_q : above_data;
		push_entry.down  = issue_s1.flush ? cur_a_data : pix_s1;
		push_entry.eor   = issue_s1.eor;
		push_entry.eof   = issue_s1.eof;
	end

	// an item in the issue stage already counts against the queue
	assign room = (int'(count_q) + int'(issue_s1.valid)) < QD;

	assign head = queue_q[rd_ptr_q];
	assign pop  = (count_q != '0) && (!out_valid_q || results.ready);
	assign sum  = (PW+2)'(head.left) + (PW+2)'(head.right)
		+ (PW+2)'(head.up) + (PW+2)'(head.down);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QD - 1) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QD - 1) ? '0 : rd_ptr_q + QAW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(pop);
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue_s1.valid) begin
			held_q <= cur_a_data;
		end
		if (push) begin
			queue_q[wr_ptr_q] <= push_entry;
		end
		if (pop) begin
			blurred_q <= PW'(sum >> NB_SHIFT);
			eor_q     <= head.eor;
			eof_q     <= head.eof;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.blurred      = PIX_PORT_W'(blurred_q);
	assign results.end_of_row   = eor_q;
	assign results.end_of_frame = eof_q;

endmodule

@@ sim/blur_result_checker.sv @@
// checker for the four-neighbour mean blur: predicts each result from the channel traffic
module blur_result_checker #(
	parameter int MAX_WIDTH  = fnmb_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = fnmb_pkg::PIXEL_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fnmb_in_if   pixels,
	fnmb_out_if  results,
	fnmb_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import fnmb_pkg::*;

	localparam logic [PIX_PORT_W-1:0] PIX_MASK = PIX_PORT_W'((64'd1 << PIXEL_BITS) - 64'd1);

	typedef struct packed {
		logic [PIX_PORT_W-1:0] blurred;
		logic                  eor;
		logic                  eof;
	} blur_px_t;

	logic [PIX_PORT_W-1:0] upper_line [MAX_WIDTH];
	logic [PIX_PORT_W-1:0] this_line [MAX_WIDTH];
	logic [PIX_PORT_W-1:0] left_held;
	int unsigned           width_set;
	int unsigned           height_set;
	int unsigned           col_at;
	int unsigned           row_at;
	int unsigned           drain_at;
	int                    fail_count;
	blur_px_t              due_q[$];

	function automatic int unsigned in_use(int unsigned v, int unsigned top);
		if (v < 1) return 1;
		if (v > top) return top;
		return v;
	endfunction

	function automatic logic [PIX_PORT_W-1:0] quarter(logic [PIX_PORT_W+1:0] sum);
		return PIX_PORT_W'(sum >> NB_SHIFT) & PIX_MASK;
	endfunction

	task automatic restart_frame();
		col_at    = 0;
		row_at    = 0;
		drain_at  = 0;
		left_held = '0;
	endtask

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
	endtask

	task automatic forecast(input logic m, input logic [PIX_PORT_W-1:0] raw);
		int unsigned           w;
		int unsigned           h;
		int unsigned           c;
		int unsigned           li;
		int unsigned           ri;
		logic [PIX_PORT_W+1:0] sum;
		logic [PIX_PORT_W-1:0] px;
		logic [PIX_PORT_W-1:0] old;
		logic [PIX_PORT_W-1:0] left;
		blur_px_t              e;
		w  = in_use(width_set, MAX_WIDTH);
		h  = in_use(height_set, MAX_HEIGHT);
		px = raw & PIX_MASK;
		if (m == MODE_FLUSH) begin
			// flushes only count once every row of the frame is in
			if (row_at < h) return;
			c   = (drain_at >= w) ? w - 1 : drain_at;
			li  = (c == 0) ? 0 : c - 1;
			ri  = (c + 1 >= w) ? c : c + 1;
			// the last row stands in as its own lower neighbour
			sum = this_line[li] + this_line[ri] + upper_line[c] + this_line[c];
			e.blurred = quarter(sum);
			e.eor     = (c + 1 >= w);
			e.eof     = (c + 1 >= w);
			due_q.push_back(e);
			if (c + 1 >= w) restart_frame();
			else drain_at = c + 1;
		end else begin
			if (row_at >= h) return;
			c = (col_at >= w) ? w - 1 : col_at;
			if (row_at == 0) begin
				upper_line[c] = px;
				this_line[c]  = px;
			end else begin
				ri   = (c + 1 >= w) ? c : c + 1;
				old  = this_line[c];
				left = (c == 0) ? old : left_held;
				sum  = left + this_line[ri] + upper_line[c] + px;
				e.blurred = quarter(sum);
				e.eor     = (c + 1 >= w);
				e.eof     = 1'b0;
				due_q.push_back(e);
				left_held     = old;
				upper_line[c] = old;
				this_line[c]  = px;
			end
			if (c + 1 >= w) begin
				col_at = 0;
				row_at++;
			end else begin
				col_at = c + 1;
			end
		end
	endtask

	task automatic compare_result(input blur_px_t got);
		blur_px_t want;
		if (due_q.size() == 0) begin
			flag($sformatf("result with nothing due: blurred=%h eor=%b eof=%b",
				got.blurred, got.eor, got.eof));
			return;
		end
		want = due_q.pop_front();
		if (got !== want)
			flag($sformatf("expected blurred=%h eor=%b eof=%b, got blurred=%h eor=%b eof=%b",
				want.blurred, want.eor, want.eof, got.blurred, got.eor, got.eof));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_set  = WIDTH_RESET;
			height_set = HEIGHT_RESET;
			restart_frame();
			due_q.delete();
			fail_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (results.valid && results.ready)
				compare_result({results.blurred, results.end_of_row, results.end_of_frame});
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_FRAME_WIDTH) width_set = cfg.data;
				else height_set = cfg.data;
				restart_frame();
			end
			if (pixels.valid && pixels.ready) forecast(pixels.mode, pixels.pixel_in);
			mismatches  <= fail_count;
			outstanding <= due_q.size();
		end
	end

endmodule

@@ sim/testbench.sv @@
// stimulus and verdict for the four-neighbour mean blur
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import fnmb_pkg::*;

	localparam int LINE_MAX     = MAX_WIDTH_DEF;
	localparam int STREAM_ITEMS = 1450;
	localparam int EDGE_ITEMS   = 150;

	logic clk;
	logic arst_n;
	bit   calm = 1'b0;
	int   stall_left = 0;
	int   mismatches;
	int   outstanding;
	int   stream_items = 0;

	fnmb_in_if  pix_ch ();
	fnmb_out_if res_ch ();
	fnmb_cfg_if cfg_ch ();

	four_neighbor_mean_blur dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix_ch),
		.results(res_ch),
		.cfg    (cfg_ch)
	);

	blur_result_checker blur_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pix_ch),
		.results    (res_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

	// result side: mostly ready, short stalls and now and then a long one
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left   <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 99) < 15) begin
				res_ch.ready <= 1'b0;
				stall_left   <= ($urandom_range(0, 5) == 0) ? $urandom_range(8, 19)
					: $urandom_range(0, 2);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 20);
	endfunction

	function automatic logic [PIX_PORT_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(PIX_PORT_W-1){1'b0}}};
			default: return PIX_PORT_W'($urandom);
		endcase
	endfunction

	function automatic int unsigned size_in_use(int unsigned raw);
		if (raw == 0) return 1;
		if (raw > LINE_MAX) return LINE_MAX;
		return raw;
	endfunction

	task automatic send_item(input logic m, input logic [PIX_PORT_W-1:0] px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid    <= 1'b1;
		pix_ch.mode     <= m;
		pix_ch.pixel_in <= px;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
	endtask

	task automatic settle();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// a dropped item may still be on its way through the pipeline
		repeat (8) @(posedge clk);
	endtask

	task automatic set_reg(input cfg_reg_t idx, input int unsigned value);
		settle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_W'(value);
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// whole frame of w by h pixels then its drain; stops early at abort_at
	task automatic run_frame(input int unsigned w, input int unsigned h, input int abort_at,
			input bit noisy, output bit done);
		int n;
		done = 1'b0;
		n = w * h;
		for (int i = 0; i < n; i++) begin
			if (i == abort_at) return;
			if (noisy && $urandom_range(0, 19) == 0) send_item(MODE_FLUSH, pick_pixel());
			send_item(MODE_PIXEL, pick_pixel());
			stream_items++;
		end
		for (int j = 0; j < int'(w); j++) begin
			if (noisy && $urandom_range(0, 19) == 0) send_item(MODE_PIXEL, pick_pixel());
			send_item(MODE_FLUSH, pick_pixel());
			stream_items++;
		end
		done = 1'b1;
	endtask

	initial begin
		int unsigned raw_w;
		int unsigned raw_h;
		int          abort_at;
		bit          clean;
		pix_ch.valid    <= 1'b0;
		pix_ch.mode     <= MODE_PIXEL;
		pix_ch.pixel_in <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= REG_FRAME_WIDTH;
		cfg_ch.data     <= '0;
		arst_n          <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// part of a first row at the reset geometry, then a write restarts the frame
		repeat (5) send_item(MODE_PIXEL, pick_pixel());

		set_reg(REG_FRAME_WIDTH, 3);
		set_reg(REG_FRAME_HEIGHT, 3);
		send_item(MODE_FLUSH, '1);
		send_item(MODE_PIXEL, 16'h0000);
		send_item(MODE_PIXEL, 16'hFFFF);
		send_item(MODE_PIXEL, 16'h8000);
		send_item(MODE_FLUSH, '0);
		send_item(MODE_PIXEL, 16'hFFFF);
		send_item(MODE_PIXEL, 16'h0001);
		send_item(MODE_PIXEL, 16'hFFFF);
		send_item(MODE_PIXEL, 16'h5555);
		send_item(MODE_PIXEL, 16'hAAAA);
		send_item(MODE_PIXEL, 16'h0000);
		// frame complete: this pixel is dropped
		send_item(MODE_PIXEL, 16'h1234);
		repeat (3) send_item(MODE_FLUSH, 16'hFFFF);

		set_reg(REG_FRAME_WIDTH, 1);
		set_reg(REG_FRAME_HEIGHT, 1);
		send_item(MODE_PIXEL, 16'hFFFF);
		send_item(MODE_FLUSH, 16'h0000);

		raw_w = 1;
		raw_h = 1;
		clean = 1'b1;
		while (stream_items < STREAM_ITEMS - 2 * EDGE_ITEMS) begin
			calm <= ($urandom_range(0, 4) == 0);
			if (!clean || $urandom_range(0, 2) != 0) begin
				case ($urandom_range(0, 9))
					0: raw_w = 0;
					1: raw_w = $urandom_range(9, 48);
					default: raw_w = $urandom_range(1, 8);
				endcase
				case ($urandom_range(0, 9))
					0: raw_h = 0;
					1: raw_h = $urandom_range(6, 12);
					default: raw_h = $urandom_range(1, 5);
				endcase
				case ($urandom_range(0, 3))
					0: set_reg(REG_FRAME_WIDTH, raw_w);
					1: set_reg(REG_FRAME_HEIGHT, raw_h);
					default: begin
						set_reg(REG_FRAME_WIDTH, raw_w);
						set_reg(REG_FRAME_HEIGHT, raw_h);
					end
				endcase
			end
			abort_at = ($urandom_range(0, 9) == 0)
				? $urandom_range(0, size_in_use(raw_w) * size_in_use(raw_h) - 1) : -1;
			run_frame(size_in_use(raw_w), size_in_use(raw_h), abort_at, 1'b1, clean);
		end

		// widest line: over-range width and a zero height, cut short
		calm <= 1'b0;
		set_reg(REG_FRAME_WIDTH, 4095);
		set_reg(REG_FRAME_HEIGHT, 0);
		run_frame(LINE_MAX, 1, EDGE_ITEMS, 1'b0, clean);
		// tallest frame: zero width and over-range height, cut short
		set_reg(REG_FRAME_WIDTH, 0);
		set_reg(REG_FRAME_HEIGHT, 4095);
		run_frame(1, MAX_HEIGHT, EDGE_ITEMS, 1'b0, clean);

		settle();
		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/fnmb_pkg.sv
hw/rtl/fnmb_ifs.sv
hw/rtl/fnmb_ram.sv
hw/rtl/fnmb_front.sv
hw/rtl/fnmb_back.sv
hw/rtl/four_neighbor_mean_blur.sv
sim/blur_result_checker.sv
sim/testbench.sv
